[src/wave_grid_stencil_step_defines.svh]
// Assertion macros shared by the wave grid stencil RTL.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef WAVE_GRID_STENCIL_STEP_DEFINES_SVH
`define WAVE_GRID_STENCIL_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wave grid implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wave grid next-cycle check failed");

`endif

[src/wgs_pkg.sv]
// Types, constants and helpers of the wave grid stencil block.
// Depends on nothing.
package wgs_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int HEIGHT_BITS = 24;
	localparam int COEF_FRAC   = 14;
	localparam int DEPTH       = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int DIM_W       = 7;
	localparam int IDX_W       = 6;
	localparam int SUM_W       = HEIGHT_BITS + 5;

	typedef logic signed [HEIGHT_BITS-1:0] height_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		MODE_TICK, MODE_DISTURB, MODE_READ, MODE_NONE
	} mode_t;

	typedef enum logic [2:0] {
		REG_COEF_PREV, REG_COEF_CENTER, REG_COEF_NEIGHBOR,
		REG_STEP_PERIOD, REG_GRID_ROWS, REG_GRID_COLS
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ADDR, ST_DIST, ST_READ, ST_RDATA,
		ST_CELL, ST_MUL, ST_SUM, ST_DONE
	} state_t;

	// Saturate a wide signed sum to the height range.
	function automatic height_t sat_height(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(HEIGHT_BITS-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return height_t'(hi);
		end else if (v < lo) begin
			return height_t'(lo);
		end
		return v[HEIGHT_BITS-1:0];
	endfunction

endpackage

[src/wave_grid_stencil_step.sv]
// Wave grid stencil step: two height grids in block RAM and a cell sequencer.
// Depends on wgs_pkg and wave_grid_stencil_step_defines.svh.
//
// Usage: items enter on in_valid/in_ready (mode, elapsed, row, col,
// magnitude); one result beat per item leaves on out_valid/out_ready
// (height, stepped, rejected). Registers are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high.
// One item is worked at a time. A stepping tick walks every interior cell
// in turn through ST_CELL (reads of the center and its four neighbors on the
// single read port of the current grid), ST_MUL (multiply) and ST_SUM (sum
// and write-back). After reset both grids are swept to zero, one entry per
// cycle over all 4096 entries, while in_ready stays low. A finished result
// sits in the output register; the next item is taken while it waits, and
// that item stalls at its end until the output register is free.
`include "wave_grid_stencil_step_defines.svh"

module wave_grid_stencil_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [15:0]             elapsed,
	input  logic [5:0]              row,
	input  logic [5:0]              col,
	input  wgs_pkg::height_t        magnitude,
	output logic                    out_valid,
	input  logic                    out_ready,
	output wgs_pkg::height_t        height,
	output logic                    stepped,
	output logic                    rejected
);
	import wgs_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic signed [15:0] coef_prev_q, coef_center_q, coef_neighbor_q;
	logic [15:0]        step_period_q;
	logic [DIM_W-1:0]   grid_rows_q, grid_cols_q;

	// Control state.
	logic               cur_is_b_q;
	logic [15:0]        time_q;
	addr_t              clr_q;
	logic [2:0]         ph_q;
	logic [IDX_W-1:0]   i_q, j_q;
	addr_t              base_q, last_q;

	// Latched input item.
	mode_t              mode_q;
	logic [15:0]        elapsed_q;
	logic [IDX_W-1:0]   row_q, col_q;
	height_t            mag_q;

	// Cell datapath.
	height_t                   ctr_q, prv_val_q;
	logic signed [HEIGHT_BITS+1:0] nsum_q;
	logic signed [HEIGHT_BITS+1:0] p0_q, p1_q;
	logic signed [HEIGHT_BITS+3:0] p2_q;

	// Pending result and output register.
	height_t            res_height_q;
	logic               res_stepped_q, res_rej_q;
	logic               out_valid_q;
	height_t            height_q;
	logic               stepped_q, rejected_q;

	// Memories.
	height_t mem_a [DEPTH];
	height_t mem_b [DEPTH];
	height_t rd_a_q, rd_b_q;
	addr_t   ra_a, ra_b, waddr, cur_raddr;
	height_t wdata;
	logic    we_a, we_b, we_cur, we_prv, clr_we;

	// Derived values.
	logic [DIM_W-1:0] eff_rows, eff_cols;
	logic [ADDR_W:0]  lin;
	logic [16:0]      tsum;
	logic [15:0]      tsat;
	logic             do_step, interior, dist_ok, read_ok, last_col, last_row;
	height_t          cur_rd, prv_rd, half, dadd;
	addr_t            ofs_addr;
	logic             in_acc, out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign height    = height_q;
	assign stepped   = stepped_q;
	assign rejected  = rejected_q;

	// Effective grid size, address and range decisions.
	always_comb begin
		eff_rows = (grid_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_q;
		eff_cols = (grid_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_q;
		lin      = (ADDR_W+1)'(row_q) * (ADDR_W+1)'(eff_cols) + (ADDR_W+1)'(col_q);
		tsum     = {1'b0, time_q} + {1'b0, elapsed_q};
		tsat     = tsum[16] ? 16'hFFFF : tsum[15:0];
		do_step  = (tsat >= step_period_q);
		interior = (eff_rows > DIM_W'(2)) && (eff_cols > DIM_W'(2));
		dist_ok  = (row_q > IDX_W'(1)) && (DIM_W'(row_q) + DIM_W'(2) < eff_rows)
			&& (col_q > IDX_W'(1)) && (DIM_W'(col_q) + DIM_W'(2) < eff_cols);
		read_ok  = (DIM_W'(row_q) < eff_rows) && (DIM_W'(col_q) < eff_cols);
		last_col = (DIM_W'(j_q) == eff_cols - DIM_W'(2));
		last_row = (DIM_W'(i_q) == eff_rows - DIM_W'(2));
		cur_rd   = cur_is_b_q ? rd_b_q : rd_a_q;
		prv_rd   = cur_is_b_q ? rd_a_q : rd_b_q;
		half     = mag_q >>> 1;
		dadd     = sat_height(SUM_W'(cur_rd) + SUM_W'((ph_q == 3'd1) ? mag_q : half));
	end

	// Center and its four neighbors, visited in phase order.
	always_comb begin
		case (ph_q)
			3'd0:    ofs_addr = base_q;
			3'd1:    ofs_addr = base_q + addr_t'(1);
			3'd2:    ofs_addr = base_q - addr_t'(1);
			3'd3:    ofs_addr = base_q + addr_t'(eff_cols);
			default: ofs_addr = base_q - addr_t'(eff_cols);
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == addr_t'(DEPTH-1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc) state_d = ST_ADDR;
			ST_ADDR: begin
				unique case (mode_q)
					MODE_TICK:    state_d = (do_step && interior) ? ST_CELL : ST_DONE;
					MODE_DISTURB: state_d = dist_ok ? ST_DIST : ST_DONE;
					MODE_READ:    state_d = read_ok ? ST_READ : ST_DONE;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_DIST:  if (ph_q == 3'd5) state_d = ST_DONE;
			ST_READ:  state_d = ST_RDATA;
			ST_RDATA: state_d = ST_DONE;
			ST_CELL:  if (ph_q == 3'd5) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = (last_col && last_row) ? ST_DONE : ST_CELL;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		clr_we    = (state_q == ST_CLEAR);
		we_cur    = (state_q == ST_DIST) && (ph_q != 3'd0);
		we_prv    = (state_q == ST_SUM);
		cur_raddr = ofs_addr;
		waddr     = base_q;
		wdata     = sat_height(SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q));
		if (clr_we) begin
			waddr = clr_q;
			wdata = '0;
		end else if (we_cur) begin
			waddr = last_q;
			wdata = dadd;
		end
		ra_a = cur_is_b_q ? base_q : cur_raddr;
		ra_b = cur_is_b_q ? cur_raddr : base_q;
		we_a = clr_we || (cur_is_b_q ? we_prv : we_cur);
		we_b = clr_we || (cur_is_b_q ? we_cur : we_prv);
	end

	// Grid memories with registered read data.
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		rd_a_q <= mem_a[ra_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
		rd_b_q <= mem_b[ra_b];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_prev_q     <= '0;
			coef_center_q   <= '0;
			coef_neighbor_q <= '0;
			step_period_q   <= '0;
			grid_rows_q     <= DIM_W'(MAX_ROWS);
			grid_cols_q     <= DIM_W'(MAX_COLS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_PREV:     coef_prev_q     <= cfg_data;
				REG_COEF_CENTER:   coef_center_q   <= cfg_data;
				REG_COEF_NEIGHBOR: coef_neighbor_q <= cfg_data;
				REG_STEP_PERIOD:   step_period_q   <= cfg_data;
				REG_GRID_ROWS:     grid_rows_q     <= cfg_data[DIM_W-1:0];
				REG_GRID_COLS:     grid_cols_q     <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_is_b_q  <= 1'b0;
			time_q      <= '0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (state_q == ST_ADDR && mode_q == MODE_TICK) begin
				time_q <= do_step ? 16'd0 : tsat;
				if (do_step && !interior) begin
					cur_is_b_q <= !cur_is_b_q;
				end
			end
			if (state_q == ST_SUM && last_col && last_row) begin
				cur_is_b_q <= !cur_is_b_q;
			end
			if (state_q == ST_DIST || state_q == ST_CELL) begin
				ph_q <= (ph_q == 3'd5) ? 3'd0 : ph_q + 3'd1;
			end else begin
				ph_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, cell and result datapath.
	always_ff @(posedge clk) begin
		last_q <= ofs_addr;
		if (in_acc) begin
			mode_q    <= mode_t'(mode);
			elapsed_q <= elapsed;
			row_q     <= row;
			col_q     <= col;
			mag_q     <= magnitude;
		end
		case (state_q)
			ST_ADDR: begin
				res_height_q  <= '0;
				res_stepped_q <= (mode_q == MODE_TICK) && do_step;
				res_rej_q     <= ((mode_q == MODE_DISTURB) && !dist_ok)
					|| ((mode_q == MODE_READ) && !read_ok);
				base_q        <= (mode_q == MODE_TICK) ? addr_t'(eff_cols) + addr_t'(1)
					: lin[ADDR_W-1:0];
				i_q           <= IDX_W'(1);
				j_q           <= IDX_W'(1);
			end
			ST_RDATA: res_height_q <= cur_rd;
			ST_CELL: begin
				if (ph_q == 3'd1) begin
					ctr_q     <= cur_rd;
					prv_val_q <= prv_rd;
				end else if (ph_q == 3'd2) begin
					nsum_q <= (HEIGHT_BITS+2)'(cur_rd);
				end else if (ph_q != 3'd0) begin
					nsum_q <= nsum_q + (HEIGHT_BITS+2)'(cur_rd);
				end
			end
			ST_MUL: begin
				p0_q <= (HEIGHT_BITS+2)'((40'(coef_prev_q) * 40'(prv_val_q)) >>> COEF_FRAC);
				p1_q <= (HEIGHT_BITS+2)'((40'(coef_center_q) * 40'(ctr_q)) >>> COEF_FRAC);
				p2_q <= (HEIGHT_BITS+4)'((42'(coef_neighbor_q) * 42'(nsum_q)) >>> COEF_FRAC);
			end
			ST_SUM: begin
				if (last_col) begin
					i_q    <= i_q + IDX_W'(1);
					j_q    <= IDX_W'(1);
					base_q <= base_q + addr_t'(3);
				end else begin
					j_q    <= j_q + IDX_W'(1);
					base_q <= base_q + addr_t'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					height_q   <= res_height_q;
					stepped_q  <= res_stepped_q;
					rejected_q <= res_rej_q;
				end
			end
			default: ;
		endcase
	end

	// Checks on the sequencer and memory controls.
	`WGS_ASSERT_IMP(a_one_grid_written, !clr_we, !(we_a && we_b))
	`WGS_ASSERT_IMP(a_step_writes_prev, we_prv, cur_is_b_q ? we_a : we_b)
	`WGS_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q == ST_ADDR)
	`WGS_ASSERT_IMP(a_no_mixed_flags, out_valid_q, !(stepped_q && rejected_q))

endmodule
